// ===== hw/rtl/sfp_pkg.sv =====
// Shared types, constants and codes for the start-of-frame parser with CRC16 check.
package sfp_pkg;

	// Payload limits and the widths that follow from them.
	localparam int MAX_PAYLOAD = 32;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

	// CRC16, reflected polynomial, no final inversion.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam int CRC_BITS_PER_STEP = 2;
	localparam int CRC_STEPS         = 8 / CRC_BITS_PER_STEP;
	localparam int CRC_STEP_W        = $clog2(CRC_STEPS);
	localparam logic [CRC_STEP_W-1:0] CRC_STEP_LAST = CRC_STEP_W'(CRC_STEPS - 1);

	// Configuration register indexes.
	localparam logic REG_SOF_FIRST  = 1'b0;
	localparam logic REG_SOF_SECOND = 1'b1;

	// Reset values of the start bytes.
	localparam logic [7:0] SOF_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SOF_SECOND_RST = 8'h55;

	// Result kinds.
	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_LEN_ERR = 2'd1;
	localparam logic [1:0] KIND_CRC_ERR = 2'd2;

	// Frame parsing phase.
	typedef enum logic [3:0] {
		PH_HUNT,
		PH_SOF2,
		PH_TYPE,
		PH_CMD,
		PH_SEQ,
		PH_LEN,
		PH_PAYLOAD,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	// Sequencer state.
	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_CRC,
		SQ_READ,
		SQ_LOAD,
		SQ_SEND
	} seq_state_t;

	// Command to the CRC unit.
	typedef struct packed {
		logic       start;
		logic       init;
		logic [7:0] data;
	} crc_cmd_t;

	// Status from the CRC unit.
	typedef struct packed {
		logic busy;
		logic done;
	} crc_sts_t;

	// One result item.
	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       frame_type;
		logic [7:0]       command;
		logic [7:0]       sequence_res;
		logic [LEN_W-1:0] payload_length;
		logic [ADDR_W-1:0] payload_position;
		logic [7:0]       payload_byte;
		logic             last;
	} result_t;

endpackage

// ===== hw/rtl/sof_frame_parser_crc16.sv =====
// Top level: frame hunter and parser with CRC16 check and payload replay.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  received byte
//  m_*       out        m_tvalid/m_tready  parse result, one per replayed payload byte, else one per frame
//  cfg_*     in         cfg_we             start byte values
//
// Each accepted byte that enters the CRC is folded in by the shared CRC unit, which
// folds two bits per cycle; input is held off until it is done. Other bytes do not
// wait. A good frame with payload is replayed from the payload RAM through the read,
// load and send states for each result. Input is held off while a result waits.
// Reset is asynchronous and active low; the payload RAM needs no clearing pass.
module sof_frame_parser_crc16 (
	input  logic        clk,
	input  logic        arst_n,
	// rx_byte [7:0]
	input  logic [7:0]  s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// frame_type [7:0], command [15:8], sequence_res [23:16], payload_length [29:24],
	// payload_position [34:30], payload_byte [42:35], zero fill [47:43]
	output logic [47:0] m_tdata,
	// result_kind [1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [7:0]  cfg_wdata
);

	localparam int AW = sfp_pkg::ADDR_W;
	localparam int LW = sfp_pkg::LEN_W;

	sfp_pkg::seq_state_t state_q, state_d;
	sfp_pkg::phase_t     phase_q, phase_d;
	logic [LW-1:0]       cnt_q, cnt_d;
	logic [LW-1:0]       cnt_inc;
	logic [7:0]          type_q, type_d;
	logic [7:0]          cmd_q, cmd_d;
	logic [7:0]          seq_q, seq_d;
	logic [LW-1:0]       len_q, len_d;
	logic [7:0]          crc_lo_q, crc_lo_d;
	logic [LW-1:0]       emit_len_q, emit_len_d;
	logic [AW-1:0]       emit_pos_q, emit_pos_d;
	logic                emit_last;
	logic [7:0]          sof1_q, sof2_q;
	sfp_pkg::result_t    out_q, out_d;
	logic                out_valid_q, out_valid_d;
	logic                in_acc;
	logic                out_acc;
	logic [7:0]          rx;
	logic                ram_we;
	logic [7:0]          ram_rdata;
	sfp_pkg::crc_cmd_t   crc_cmd;
	sfp_pkg::crc_sts_t   crc_sts;
	logic [15:0]         crc_val;

	assign rx       = s_tdata;
	assign s_tready = (state_q == sfp_pkg::SQ_IDLE) && !out_valid_q;
	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign cnt_inc  = cnt_q + 1'b1;
	assign emit_last = (({1'b0, emit_pos_q} + 1'b1) == emit_len_q);

	// Shared CRC unit.
	sfp_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (crc_cmd),
		.sts    (crc_sts),
		.crc    (crc_val)
	);

	// Payload store, written while receiving and read back while replaying.
	sfp_ram #(
		.WIDTH (8),
		.DEPTH (sfp_pkg::MAX_PAYLOAD)
	) u_payload (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (rx),
		.raddr (emit_pos_q),
		.rdata (ram_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof1_q <= sfp_pkg::SOF_FIRST_RST;
			sof2_q <= sfp_pkg::SOF_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				sfp_pkg::REG_SOF_FIRST:  sof1_q <= cfg_wdata;
				sfp_pkg::REG_SOF_SECOND: sof2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer and frame parser: next state and outputs.
	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		type_d      = type_q;
		cmd_d       = cmd_q;
		seq_d       = seq_q;
		len_d       = len_q;
		crc_lo_d    = crc_lo_q;
		emit_len_d  = emit_len_q;
		emit_pos_d  = emit_pos_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !out_acc;
		ram_we      = 1'b0;
		crc_cmd     = '{start: 1'b0, init: 1'b0, data: rx};

		case (state_q)
			sfp_pkg::SQ_IDLE: begin
				if (in_acc) begin
					case (phase_q)
						sfp_pkg::PH_HUNT: begin
							if (rx == sof1_q) begin
								crc_cmd.start = 1'b1;
								crc_cmd.init  = 1'b1;
								cnt_d   = '0;
								len_d   = '0;
								cmd_d   = '0;
								seq_d   = '0;
								phase_d = sfp_pkg::PH_SOF2;
								state_d = sfp_pkg::SQ_CRC;
							end
						end
						sfp_pkg::PH_SOF2: begin
							if (rx == sof2_q) begin
								crc_cmd.start = 1'b1;
								phase_d = sfp_pkg::PH_TYPE;
								state_d = sfp_pkg::SQ_CRC;
							end else if (rx == sof1_q) begin
								// Repeated first start byte opens a fresh frame.
								crc_cmd.start = 1'b1;
								crc_cmd.init  = 1'b1;
								cnt_d   = '0;
								len_d   = '0;
								cmd_d   = '0;
								seq_d   = '0;
								phase_d = sfp_pkg::PH_SOF2;
								state_d = sfp_pkg::SQ_CRC;
							end else begin
								phase_d = sfp_pkg::PH_HUNT;
								cnt_d   = '0;
								len_d   = '0;
							end
						end
						sfp_pkg::PH_TYPE: begin
							type_d  = rx;
							crc_cmd.start = 1'b1;
							phase_d = sfp_pkg::PH_CMD;
							state_d = sfp_pkg::SQ_CRC;
						end
						sfp_pkg::PH_CMD: begin
							cmd_d   = rx;
							crc_cmd.start = 1'b1;
							phase_d = sfp_pkg::PH_SEQ;
							state_d = sfp_pkg::SQ_CRC;
						end
						sfp_pkg::PH_SEQ: begin
							seq_d   = rx;
							crc_cmd.start = 1'b1;
							phase_d = sfp_pkg::PH_LEN;
							state_d = sfp_pkg::SQ_CRC;
						end
						sfp_pkg::PH_LEN: begin
							if (rx > 8'(sfp_pkg::MAX_PAYLOAD)) begin
								// Oversized length: report and resume hunting.
								out_d = '{kind: sfp_pkg::KIND_LEN_ERR, frame_type: 8'h00,
									command: cmd_q, sequence_res: seq_q,
									payload_length: '0, payload_position: '0,
									payload_byte: 8'h00, last: 1'b1};
								out_valid_d = 1'b1;
								phase_d = sfp_pkg::PH_HUNT;
								cnt_d   = '0;
								len_d   = '0;
							end else begin
								len_d   = rx[LW-1:0];
								cnt_d   = '0;
								crc_cmd.start = 1'b1;
								phase_d = (rx == 8'h00) ? sfp_pkg::PH_CRC_LO
									: sfp_pkg::PH_PAYLOAD;
								state_d = sfp_pkg::SQ_CRC;
							end
						end
						sfp_pkg::PH_PAYLOAD: begin
							ram_we  = 1'b1;
							crc_cmd.start = 1'b1;
							cnt_d   = cnt_inc;
							if (cnt_inc >= len_q) begin
								phase_d = sfp_pkg::PH_CRC_LO;
							end
							state_d = sfp_pkg::SQ_CRC;
						end
						sfp_pkg::PH_CRC_LO: begin
							crc_lo_d = rx;
							phase_d  = sfp_pkg::PH_CRC_HI;
						end
						sfp_pkg::PH_CRC_HI: begin
							if ({rx, crc_lo_q} == crc_val) begin
								if (len_q == '0) begin
									// Header-only frame.
									out_d = '{kind: sfp_pkg::KIND_DATA, frame_type: type_q,
										command: cmd_q, sequence_res: seq_q,
										payload_length: '0, payload_position: '0,
										payload_byte: 8'h00, last: 1'b1};
									out_valid_d = 1'b1;
								end else begin
									emit_len_d = len_q;
									emit_pos_d = '0;
									state_d    = sfp_pkg::SQ_READ;
								end
							end else begin
								out_d = '{kind: sfp_pkg::KIND_CRC_ERR, frame_type: 8'h00,
									command: cmd_q, sequence_res: seq_q,
									payload_length: '0, payload_position: '0,
									payload_byte: 8'h00, last: 1'b1};
								out_valid_d = 1'b1;
							end
							phase_d = sfp_pkg::PH_HUNT;
							cnt_d   = '0;
							len_d   = '0;
						end
						default: begin
							phase_d = sfp_pkg::PH_HUNT;
							cnt_d   = '0;
							len_d   = '0;
						end
					endcase
				end
			end
			sfp_pkg::SQ_CRC: begin
				if (crc_sts.done) begin
					state_d = sfp_pkg::SQ_IDLE;
				end
			end
			sfp_pkg::SQ_READ: begin
				// The RAM address is the replay position; data arrives next cycle.
				state_d = sfp_pkg::SQ_LOAD;
			end
			sfp_pkg::SQ_LOAD: begin
				out_d = '{kind: sfp_pkg::KIND_DATA, frame_type: type_q,
					command: cmd_q, sequence_res: seq_q,
					payload_length: emit_len_q, payload_position: emit_pos_q,
					payload_byte: ram_rdata, last: emit_last};
				out_valid_d = 1'b1;
				state_d = sfp_pkg::SQ_SEND;
			end
			sfp_pkg::SQ_SEND: begin
				if (out_acc) begin
					if (out_q.last) begin
						state_d = sfp_pkg::SQ_IDLE;
					end else begin
						emit_pos_d = emit_pos_q + 1'b1;
						state_d    = sfp_pkg::SQ_READ;
					end
				end
			end
			default: begin
				state_d = sfp_pkg::SQ_IDLE;
			end
		endcase
	end

	// Control and held header registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfp_pkg::SQ_IDLE;
			phase_q     <= sfp_pkg::PH_HUNT;
			cnt_q       <= '0;
			type_q      <= '0;
			cmd_q       <= '0;
			seq_q       <= '0;
			len_q       <= '0;
			emit_len_q  <= '0;
			emit_pos_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			type_q      <= type_d;
			cmd_q       <= cmd_d;
			seq_q       <= seq_d;
			len_q       <= len_d;
			emit_len_q  <= emit_len_d;
			emit_pos_q  <= emit_pos_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload registers: received CRC low byte and the output request.
	always_ff @(posedge clk) begin
		crc_lo_q <= crc_lo_d;
		out_q    <= out_d;
	end

	// Output packing.
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {5'b00000, out_q.payload_byte, out_q.payload_position,
		out_q.payload_length, out_q.sequence_res, out_q.command, out_q.frame_type};

endmodule

// ===== hw/rtl/sfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/sfp_crc_unit.sv =====
// Iterative CRC16 unit: folds one byte into the running CRC a few bits per cycle.
module sfp_crc_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  sfp_pkg::crc_cmd_t cmd,
	output sfp_pkg::crc_sts_t sts,
	output logic [15:0]       crc
);

	logic [15:0]                       crc_q;
	logic [15:0]                       work;
	logic [sfp_pkg::CRC_STEP_W-1:0]    step_q;
	logic                              busy_q;

	// Shift-and-reduce over the bits handled in one cycle.
	always_comb begin
		work = crc_q;
		for (int k = 0; k < sfp_pkg::CRC_BITS_PER_STEP; k++) begin
			if (work[0]) begin
				work = (work >> 1) ^ sfp_pkg::CRC_POLY;
			end else begin
				work = work >> 1;
			end
		end
	end

	// Running CRC and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= sfp_pkg::CRC_INIT;
			step_q <= '0;
			busy_q <= 1'b0;
		end else if (cmd.start) begin
			crc_q  <= (cmd.init ? sfp_pkg::CRC_INIT : crc_q) ^ {8'h00, cmd.data};
			step_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q  <= work;
			step_q <= step_q + 1'b1;
			if (step_q == sfp_pkg::CRC_STEP_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = busy_q && (step_q == sfp_pkg::CRC_STEP_LAST);
	assign crc      = crc_q;

endmodule
